[rtl/core/six_channel_pwm_with_shadow_match_assert.svh]
// Assertion macros for the six-channel PWM timer.
// Used by the top level; compiled out when SYNTHESIS is defined.
`ifndef SIX_CHANNEL_PWM_WITH_SHADOW_MATCH_ASSERT_SVH
`define SIX_CHANNEL_PWM_WITH_SHADOW_MATCH_ASSERT_SVH
`ifndef SYNTHESIS
`define SCPWM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SCPWM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCPWM_ASSERT(label, clk, rst, prop, msg)
`define SCPWM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[rtl/core/scpwm_pkg.sv]
// Shared types and constants for the six-channel PWM timer.
// No dependencies.
package scpwm_pkg;

   localparam int MAX_CHANNELS      = 6;
   localparam int NUM_CHANNELS_DEF  = 6;
   localparam int COUNT_WIDTH_DEF   = 24;
   localparam int CHAN_W            = 3;
   localparam int DUTY_W            = 24;
   localparam int PERIOD_W          = 24;
   localparam int OP_W              = 2;
   localparam int CSR_INDEX_W       = 1;
   localparam int REQ_DATA_W        = 32;
   localparam int RSP_DATA_W        = 32;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'h15F900;
   localparam logic [DUTY_W-1:0]   DUTY_RESET   = 24'h01A5E0;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PERIOD     = 1'd0,
      CSR_RUN_ENABLE = 1'd1
   } csr_index_type;

   typedef struct packed {
      op_type              op;
      logic [CHAN_W-1:0]   channel;
      logic [DUTY_W-1:0]   duty_value;
   } item_type;

   typedef struct packed {
      logic                  cycle_wrapped;
      logic                  bad_channel;
      logic [DUTY_W-1:0]     read_data;
      logic [MAX_CHANNELS-1:0] pwm_levels;
   } result_type;

   typedef struct packed {
      logic                  valid;
      csr_index_type         index;
      logic [PERIOD_W-1:0]   data;
   } csr_write_type;

   typedef struct packed {
      logic [MAX_CHANNELS-1:0] pending;
      logic                    count_zero;
   } status_type;

endpackage

[rtl/core/scpwm_req_stage.sv]
// Request input register for the PWM timer.
// Depends on scpwm_pkg.
module scpwm_req_stage (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [scpwm_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [scpwm_pkg::OP_W-1:0]            req_tuser,
   input  logic                                  advance,
   output logic                                  item_valid,
   output scpwm_pkg::item_type                   item
);

   logic                 valid_ff;
   logic                 valid_in;
   scpwm_pkg::item_type  item_ff;
   scpwm_pkg::item_type  item_in;
   logic                 accept;

   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      item_in.op         = scpwm_pkg::op_type'(req_tuser);
      item_in.channel    = req_tdata[scpwm_pkg::CHAN_W-1:0];
      item_in.duty_value = req_tdata[scpwm_pkg::CHAN_W +: scpwm_pkg::DUTY_W];
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[rtl/core/scpwm_engine.sv]
// Timer state, shadow/active match registers and per-request update logic.
// Depends on scpwm_pkg.
module scpwm_engine #(
   parameter int NUM_CHANNELS = scpwm_pkg::NUM_CHANNELS_DEF,
   parameter int COUNT_WIDTH  = scpwm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  scpwm_pkg::item_type      item,
   input  scpwm_pkg::csr_write_type csr_write,
   output scpwm_pkg::result_type    result,
   output scpwm_pkg::status_type    status
);

   localparam int DUTY_W   = scpwm_pkg::DUTY_W;
   localparam int PERIOD_W = scpwm_pkg::PERIOD_W;
   localparam int CHAN_W   = scpwm_pkg::CHAN_W;
   localparam int LEVEL_W  = scpwm_pkg::MAX_CHANNELS;
   localparam int NEXT_W   = COUNT_WIDTH + 1;
   localparam int WRAP_W   = (NEXT_W > PERIOD_W) ? NEXT_W : PERIOD_W;
   localparam int CMP_W    = (COUNT_WIDTH > DUTY_W) ? COUNT_WIDTH : DUTY_W;

   logic [PERIOD_W-1:0]    period_ff;
   logic                   run_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic [DUTY_W-1:0]      shadow_ff [NUM_CHANNELS];
   logic [DUTY_W-1:0]      shadow_in [NUM_CHANNELS];
   logic [DUTY_W-1:0]      active_ff [NUM_CHANNELS];
   logic [DUTY_W-1:0]      active_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] pending_ff;
   logic [NUM_CHANNELS-1:0] pending_in;

   logic [NEXT_W-1:0]       count_plus;
   logic                    wrap;
   logic [NUM_CHANNELS-1:0] chan_sel;
   logic                    chan_ok;
   logic [NUM_CHANNELS-1:0] levels;
   logic [DUTY_W-1:0]       read_data;
   logic                    bad;
   logic                    wrapped;

   assign count_plus = NEXT_W'(count_ff) + NEXT_W'(1);
   assign wrap = count_plus[COUNT_WIDTH] ||
                 (WRAP_W'(count_plus) >= WRAP_W'(period_ff));

   always_comb begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         chan_sel[k] = (item.channel == CHAN_W'(k + 1));
      end
   end
   assign chan_ok = |chan_sel;

   always_comb begin
      count_in   = count_ff;
      shadow_in  = shadow_ff;
      active_in  = active_ff;
      pending_in = pending_ff;
      read_data  = '0;
      bad        = 1'b0;
      wrapped    = 1'b0;
      if (fire) begin
         unique case (item.op)
            scpwm_pkg::OP_TICK: begin
               if (run_ff) begin
                  if (wrap) begin
                     count_in = '0;
                     for (int k = 0; k < NUM_CHANNELS; k++) begin
                        if (pending_ff[k]) begin
                           active_in[k] = shadow_ff[k];
                        end
                     end
                     pending_in = '0;
                     wrapped    = 1'b1;
                  end else begin
                     count_in = count_plus[COUNT_WIDTH-1:0];
                  end
               end
            end
            scpwm_pkg::OP_WRITE: begin
               if (chan_ok) begin
                  for (int k = 0; k < NUM_CHANNELS; k++) begin
                     if (chan_sel[k]) begin
                        shadow_in[k] = item.duty_value;
                     end
                  end
                  pending_in = pending_ff | chan_sel;
               end else begin
                  bad = 1'b1;
               end
            end
            scpwm_pkg::OP_READ: begin
               if (chan_ok) begin
                  for (int k = 0; k < NUM_CHANNELS; k++) begin
                     if (chan_sel[k]) begin
                        read_data = read_data | shadow_ff[k];
                     end
                  end
               end else begin
                  bad = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // levels as seen after this request
   always_comb begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         levels[k] = run_ff && (CMP_W'(count_in) < CMP_W'(active_in[k]));
      end
   end

   always_comb begin
      result.pwm_levels    = LEVEL_W'(levels);
      result.read_data     = read_data;
      result.bad_channel   = bad;
      result.cycle_wrapped = wrapped;
      status.pending       = LEVEL_W'(pending_ff);
      status.count_zero    = (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= scpwm_pkg::PERIOD_RESET;
         run_ff     <= 1'b0;
         count_ff   <= '0;
         pending_ff <= '0;
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            shadow_ff[k] <= scpwm_pkg::DUTY_RESET;
            active_ff[k] <= scpwm_pkg::DUTY_RESET;
         end
      end else begin
         if (csr_write.valid) begin
            unique case (csr_write.index)
               scpwm_pkg::CSR_PERIOD:     period_ff <= csr_write.data;
               scpwm_pkg::CSR_RUN_ENABLE: run_ff    <= csr_write.data[0];
               default: begin
               end
            endcase
         end
         count_ff   <= count_in;
         shadow_ff  <= shadow_in;
         active_ff  <= active_in;
         pending_ff <= pending_in;
      end
   end

endmodule

[rtl/core/scpwm_rsp_stage.sv]
// Result output register for the PWM timer.
// Depends on scpwm_pkg.
module scpwm_rsp_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  scpwm_pkg::result_type             result,
   output logic                              free,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [scpwm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic                   valid_ff;
   logic                   valid_in;
   scpwm_pkg::result_type  result_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = scpwm_pkg::RSP_DATA_W'(result_ff);

endmodule

[rtl/core/six_channel_pwm_with_shadow_match.sv]
// Six-channel single-edge PWM timer with shadowed match registers: top level.
// Depends on scpwm_pkg, scpwm_req_stage, scpwm_engine, scpwm_rsp_stage.
//
// Takes one request per clock (tick, duty write, duty read) and returns exactly
// one response per request: the request is held in the request register, then the
// counter/match update and level compare run in a single pass into the response
// register. Throughput is one request per cycle whenever the response side keeps
// taking data; a held response stalls at most one request behind it. Duty writes
// go to a shadow register and take effect at the next counter wrap. The CSR port
// is always ready; write it only while no request is in flight. No clearing pass
// after reset.
`include "six_channel_pwm_with_shadow_match_assert.svh"

module six_channel_pwm_with_shadow_match #(
   parameter int NUM_CHANNELS = scpwm_pkg::NUM_CHANNELS_DEF,
   parameter int COUNT_WIDTH  = scpwm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [2:0] channel, [26:3] duty_value, [31:27] zero
   input  logic [scpwm_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] op
   input  logic [scpwm_pkg::OP_W-1:0]            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [5:0] pwm_levels, [29:6] read_data, [30] bad_channel, [31] cycle_wrapped
   output logic [scpwm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [scpwm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [scpwm_pkg::PERIOD_W-1:0]        csr_data
);

   logic                     item_valid;
   scpwm_pkg::item_type      item;
   logic                     rsp_free;
   logic                     fire;
   scpwm_pkg::result_type    result;
   scpwm_pkg::status_type    status;
   scpwm_pkg::csr_write_type csr_write;

   assign csr_ready = 1'b1;
   assign fire      = item_valid && rsp_free;

   always_comb begin
      csr_write.valid = csr_valid && csr_ready;
      csr_write.index = scpwm_pkg::csr_index_type'(csr_index);
      csr_write.data  = csr_data;
   end

   scpwm_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   scpwm_engine #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item),
      .csr_write (csr_write),
      .result    (result),
      .status    (status)
   );

   scpwm_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result     (result),
      .free       (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `SCPWM_ASSERT(a_new_rsp_from_fire, clock, reset,
      rsp_tvalid && !$past(rsp_tvalid && !rsp_tready) |-> $past(fire),
      "response appeared without a processed request")
   `SCPWM_ASSERT(a_full_accept_moves, clock, reset,
      req_tvalid && req_tready && item_valid |-> fire,
      "request taken while request register held")
   `SCPWM_ASSERT(a_wrap_clears, clock, reset,
      fire && result.cycle_wrapped |=> status.count_zero && (status.pending == '0),
      "wrap left count or pending set")
   `SCPWM_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for six_channel_pwm_with_shadow_match.
// Predicts every response from its own model of the timer and checks it field by field.
// Depends on scpwm_pkg and the RTL of the block only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OP_W        = scpwm_pkg::OP_W;
   localparam int CHAN_W      = scpwm_pkg::CHAN_W;
   localparam int DUTY_W      = scpwm_pkg::DUTY_W;
   localparam int PERIOD_W    = scpwm_pkg::PERIOD_W;
   localparam int COUNT_W     = scpwm_pkg::COUNT_WIDTH_DEF;
   localparam int REQ_DATA_W  = scpwm_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W  = scpwm_pkg::RSP_DATA_W;
   localparam int CSR_INDEX_W = scpwm_pkg::CSR_INDEX_W;

   localparam int CHANNELS = scpwm_pkg::NUM_CHANNELS_DEF;
   localparam int QUIET_LIMIT = 2000;
   localparam int PRESSURE_HOLD = 300;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [DUTY_W-1:0] DUTY_MAX = 24'hFFFFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [2:0] channel, [26:3] duty_value
   logic [OP_W-1:0] req_tuser = '0;         // [1:0] op
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [5:0] levels, [29:6] read, [30] bad, [31] wrap
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [PERIOD_W-1:0] csr_data = '0;

   // timer model
   logic [PERIOD_W-1:0] period_now;
   logic run_now;
   logic [COUNT_W-1:0] count_now;
   logic [DUTY_W-1:0] shadow_duty [CHANNELS];
   logic [DUTY_W-1:0] live_duty [CHANNELS];
   logic [CHANNELS-1:0] latch_mask;

   scpwm_pkg::result_type expected_pwm_results [$];

   int mismatches = 0;
   int n_requests = 0;
   int n_responses = 0;
   int n_wraps = 0;
   int n_bad = 0;
   int n_reads = 0;
   int n_csr_writes = 0;
   int quiet_cycles = 0;

   bit sender_idles = 1'b0;
   bit receiver_idles = 1'b0;
   int rsp_hold_len = 0;

   six_channel_pwm_with_shadow_match DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      period_now = scpwm_pkg::PERIOD_RESET;
      run_now = 1'b0;
      count_now = '0;
      latch_mask = '0;
      for (int k = 0; k < CHANNELS; k++) begin
         shadow_duty[k] = scpwm_pkg::DUTY_RESET;
         live_duty[k] = scpwm_pkg::DUTY_RESET;
      end
   end

   function automatic scpwm_pkg::result_type predict_pwm_step(logic [OP_W-1:0] op,
                                                              logic [CHAN_W-1:0] ch,
                                                              logic [DUTY_W-1:0] duty);
      scpwm_pkg::result_type r;
      logic chan_ok;
      logic [COUNT_W:0] bumped;
      r = '0;
      chan_ok = (ch >= 1) && (ch <= CHANNELS);
      unique case (op)
         scpwm_pkg::OP_TICK: begin
            if (run_now) begin
               bumped = {1'b0, count_now} + 1'b1;
               if (bumped >= {1'b0, period_now} || bumped[COUNT_W]) begin
                  count_now = '0;
                  for (int k = 0; k < CHANNELS; k++)
                     if (latch_mask[k]) live_duty[k] = shadow_duty[k];
                  latch_mask = '0;
                  r.cycle_wrapped = 1'b1;
               end else begin
                  count_now = bumped[COUNT_W-1:0];
               end
            end
         end
         scpwm_pkg::OP_WRITE: begin
            if (chan_ok) begin
               shadow_duty[ch - 3'd1] = duty;
               latch_mask[ch - 3'd1] = 1'b1;
            end else begin
               r.bad_channel = 1'b1;
            end
         end
         scpwm_pkg::OP_READ: begin
            if (chan_ok) r.read_data = shadow_duty[ch - 3'd1];
            else r.bad_channel = 1'b1;
         end
         default: ;
      endcase
      if (run_now)
         for (int k = 0; k < CHANNELS; k++)
            r.pwm_levels[k] = count_now < live_duty[k];
      return r;
   endfunction

   task automatic check_field(string label, logic [DUTY_W-1:0] want, logic [DUTY_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      scpwm_pkg::result_type seen;
      scpwm_pkg::result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen = scpwm_pkg::result_type'(rsp_tdata);
            if (expected_pwm_results.size() == 0) begin
               mismatches++;
               $display("%0t: response %0h with no request outstanding", $time, rsp_tdata);
            end else begin
               want = expected_pwm_results.pop_front();
               n_responses++;
               check_field("pwm_levels", DUTY_W'(want.pwm_levels), DUTY_W'(seen.pwm_levels));
               check_field("read_data", want.read_data, seen.read_data);
               check_field("bad_channel", DUTY_W'(want.bad_channel),
                           DUTY_W'(seen.bad_channel));
               check_field("cycle_wrapped", DUTY_W'(want.cycle_wrapped),
                           DUTY_W'(seen.cycle_wrapped));
            end
         end
         if (csr_valid && csr_ready) begin
            n_csr_writes++;
            unique case (csr_index)
               scpwm_pkg::CSR_PERIOD:     period_now = csr_data;
               scpwm_pkg::CSR_RUN_ENABLE: run_now = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = predict_pwm_step(req_tuser, req_tdata[CHAN_W-1:0],
                                    req_tdata[CHAN_W +: DUTY_W]);
            expected_pwm_results.push_back(want);
            n_requests++;
            if (want.cycle_wrapped) n_wraps++;
            if (want.bad_channel) n_bad++;
            if (req_tuser == scpwm_pkg::OP_READ) n_reads++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("tb_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side back-pressure
   initial begin : receiver
      int stall_left;
      int r;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            stall_left = rsp_hold_len;
            rsp_hold_len = 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!receiver_idles) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (!sender_idles) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(logic [OP_W-1:0] op, logic [CHAN_W-1:0] ch,
                               logic [DUTY_W-1:0] duty);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {{(REQ_DATA_W-CHAN_W-DUTY_W){1'b0}}, duty, ch};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_pwm_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(scpwm_pkg::csr_index_type idx, logic [PERIOD_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_timer(logic [PERIOD_W-1:0] period, logic run);
      drain_responses();
      write_register(scpwm_pkg::CSR_PERIOD, period);
      write_register(scpwm_pkg::CSR_RUN_ENABLE, {{(PERIOD_W-1){1'b0}}, run});
   endtask

   task automatic test_stopped_timer();
      send_request(scpwm_pkg::OP_TICK, 3'd1, '0);
      send_request(scpwm_pkg::OP_READ, 3'd3, '0);
      send_request(scpwm_pkg::OP_WRITE, 3'd1, '0);
      send_request(scpwm_pkg::OP_WRITE, 3'd6, DUTY_MAX);
      send_request(scpwm_pkg::OP_READ, 3'd6, '0);
      send_request(scpwm_pkg::OP_READ, 3'd0, DUTY_MAX);
      send_request(scpwm_pkg::OP_WRITE, 3'd7, 24'h123456);
      send_request(OP_UNUSED, 3'd2, 24'hABCDEF);
   endtask

   task automatic test_shadow_latch();
      set_timer(24'd4, 1'b1);
      send_request(scpwm_pkg::OP_WRITE, 3'd2, '0);
      send_request(scpwm_pkg::OP_WRITE, 3'd5, 24'd3);
      repeat (5) send_request(scpwm_pkg::OP_TICK, 3'd0, '0);
      send_request(scpwm_pkg::OP_READ, 3'd5, '0);
      send_request(scpwm_pkg::OP_READ, 3'd7, '0);
      send_request(OP_UNUSED, 3'd4, DUTY_MAX);
      // every tick wraps
      set_timer(24'd1, 1'b1);
      repeat (2) send_request(scpwm_pkg::OP_TICK, 3'd0, '0);
      set_timer(24'd0, 1'b1);
      repeat (2) send_request(scpwm_pkg::OP_TICK, 3'd0, '0);
   endtask

   task automatic run_random_phase(logic [PERIOD_W-1:0] period, logic run, int count);
      int r;
      int span;
      logic [OP_W-1:0] op;
      logic [CHAN_W-1:0] ch;
      logic [DUTY_W-1:0] duty;
      set_timer(period, run);
      span = (period < 200) ? period + 2 : 200;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         op = (r < 55) ? scpwm_pkg::OP_TICK : (r < 80) ? scpwm_pkg::OP_WRITE :
              (r < 95) ? scpwm_pkg::OP_READ : OP_UNUSED;
         if ($urandom_range(0, 99) < 88) ch = CHAN_W'($urandom_range(1, CHANNELS));
         else ch = $urandom_range(0, 1) ? 3'd7 : 3'd0;
         r = $urandom_range(0, 99);
         if (r < 75) duty = DUTY_W'($urandom_range(0, span));
         else if (r < 93) duty = DUTY_W'($urandom);
         else duty = $urandom_range(0, 1) ? DUTY_MAX : '0;
         send_request(op, ch, duty);
      end
   endtask

   task automatic test_random_traffic();
      logic [PERIOD_W-1:0] periods [10];
      periods = '{24'd1, 24'd2, 24'd5, 24'd13, 24'd40, 24'd97, 24'd255,
                  DUTY_MAX, scpwm_pkg::PERIOD_RESET, 24'd0};
      periods[9] = PERIOD_W'($urandom_range(3, 64));
      for (int p = 0; p < 10; p++) begin
         sender_idles = (p % 3) != 0;
         receiver_idles = (p % 4) != 1;
         run_random_phase(periods[p], p != 3, 120);
      end
   endtask

   task automatic test_backpressure();
      set_timer(24'd9, 1'b1);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      rsp_hold_len = PRESSURE_HOLD;
      for (int n = 0; n < 50; n++)
         send_request(n % 3 == 2 ? scpwm_pkg::OP_WRITE : scpwm_pkg::OP_TICK,
                      CHAN_W'($urandom_range(1, CHANNELS)),
                      DUTY_W'($urandom_range(0, 11)));
      receiver_idles = 1'b1;
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_stopped_timer();
      test_shadow_latch();
      test_random_traffic();
      test_backpressure();
      drain_responses();
      repeat (10) @(posedge clock);
      $display("Ran %0d requests (%0d reads, %0d bad channel) and %0d config writes;",
               n_requests, n_reads, n_bad, n_csr_writes);
      $display("saw %0d counter wraps, %0d responses checked, %0d mismatches.",
               n_wraps, n_responses, mismatches);
      if (mismatches == 0 && expected_pwm_results.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
